/* rtl/md5_pkg.sv */
// Shared types, constants and round tables for the MD5 engine.
`timescale 1ns / 1ps
`default_nettype none

package md5_pkg;

    typedef logic [31:0] word_t;

    localparam int WORDS_PER_BLOCK = 16;

    localparam logic CMD_ABSORB = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam word_t IV_A = 32'h67452301;
    localparam word_t IV_B = 32'hEFCDAB89;
    localparam word_t IV_C = 32'h98BADCFE;
    localparam word_t IV_D = 32'h10325476;

    // Additive constant of each round.
    function automatic word_t round_k(input logic [5:0] rnd);
        word_t k;
        case (rnd)
            6'd0:  k = 32'hD76AA478;  6'd1:  k = 32'hE8C7B756;
            6'd2:  k = 32'h242070DB;  6'd3:  k = 32'hC1BDCEEE;
            6'd4:  k = 32'hF57C0FAF;  6'd5:  k = 32'h4787C62A;
            6'd6:  k = 32'hA8304613;  6'd7:  k = 32'hFD469501;
            6'd8:  k = 32'h698098D8;  6'd9:  k = 32'h8B44F7AF;
            6'd10: k = 32'hFFFF5BB1;  6'd11: k = 32'h895CD7BE;
            6'd12: k = 32'h6B901122;  6'd13: k = 32'hFD987193;
            6'd14: k = 32'hA679438E;  6'd15: k = 32'h49B40821;
            6'd16: k = 32'hF61E2562;  6'd17: k = 32'hC040B340;
            6'd18: k = 32'h265E5A51;  6'd19: k = 32'hE9B6C7AA;
            6'd20: k = 32'hD62F105D;  6'd21: k = 32'h02441453;
            6'd22: k = 32'hD8A1E681;  6'd23: k = 32'hE7D3FBC8;
            6'd24: k = 32'h21E1CDE6;  6'd25: k = 32'hC33707D6;
            6'd26: k = 32'hF4D50D87;  6'd27: k = 32'h455A14ED;
            6'd28: k = 32'hA9E3E905;  6'd29: k = 32'hFCEFA3F8;
            6'd30: k = 32'h676F02D9;  6'd31: k = 32'h8D2A4C8A;
            6'd32: k = 32'hFFFA3942;  6'd33: k = 32'h8771F681;
            6'd34: k = 32'h6D9D6122;  6'd35: k = 32'hFDE5380C;
            6'd36: k = 32'hA4BEEA44;  6'd37: k = 32'h4BDECFA9;
            6'd38: k = 32'hF6BB4B60;  6'd39: k = 32'hBEBFBC70;
            6'd40: k = 32'h289B7EC6;  6'd41: k = 32'hEAA127FA;
            6'd42: k = 32'hD4EF3085;  6'd43: k = 32'h04881D05;
            6'd44: k = 32'hD9D4D039;  6'd45: k = 32'hE6DB99E5;
            6'd46: k = 32'h1FA27CF8;  6'd47: k = 32'hC4AC5665;
            6'd48: k = 32'hF4292244;  6'd49: k = 32'h432AFF97;
            6'd50: k = 32'hAB9423A7;  6'd51: k = 32'hFC93A039;
            6'd52: k = 32'h655B59C3;  6'd53: k = 32'h8F0CCC92;
            6'd54: k = 32'hFFEFF47D;  6'd55: k = 32'h85845DD1;
            6'd56: k = 32'h6FA87E4F;  6'd57: k = 32'hFE2CE6E0;
            6'd58: k = 32'hA3014314;  6'd59: k = 32'h4E0811A1;
            6'd60: k = 32'hF7537E82;  6'd61: k = 32'hBD3AF235;
            6'd62: k = 32'h2AD7D2BB;  6'd63: k = 32'hEB86D391;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    // Rotate amount: depends on round group and round index modulo 4.
    function automatic logic [4:0] round_shift(input logic [5:0] rnd);
        logic [4:0] s;
        case ({rnd[5:4], rnd[1:0]})
            4'd0:  s = 5'd7;   4'd1:  s = 5'd12; 4'd2:  s = 5'd17; 4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;   4'd5:  s = 5'd9;  4'd6:  s = 5'd14; 4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;   4'd9:  s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
            4'd12: s = 5'd6;   4'd13: s = 5'd10; 4'd14: s = 5'd15; 4'd15: s = 5'd21;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

    // Message word used by each round.
    function automatic logic [3:0] msg_index(input logic [5:0] rnd);
        logic [3:0] r;
        logic [3:0] g;
        r = rnd[3:0];
        case (rnd[5:4])
            2'd0:    g = r;
            2'd1:    g = 4'(r * 4'd5 + 4'd1);
            2'd2:    g = 4'(r * 4'd3 + 4'd5);
            default: g = 4'(r * 4'd7);
        endcase
        return g;
    endfunction

endpackage

`default_nettype wire

/* rtl/md5_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module md5_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* rtl/md5_round.sv */
// One MD5 round: mixing function, additions and rotate.
`timescale 1ns / 1ps
`default_nettype none

module md5_round (
    input  wire logic [5:0]     rnd,
    input  wire md5_pkg::word_t a,
    input  wire md5_pkg::word_t b,
    input  wire md5_pkg::word_t c,
    input  wire md5_pkg::word_t d,
    input  wire md5_pkg::word_t w,
    output md5_pkg::word_t      b_new
);

    import md5_pkg::*;

    word_t       f;
    word_t       t;
    logic [63:0] dbl;

    always_comb begin
        case (rnd[5:4])
            2'd0:    f = (b & c) | (~b & d);
            2'd1:    f = (b & d) | (c & ~d);
            2'd2:    f = b ^ c ^ d;
            default: f = c ^ (b | ~d);
        endcase
        t     = a + f + w + round_k(rnd);
        dbl   = {t, t} << round_shift(rnd);
        b_new = b + dbl[63:32];
    end

endmodule

`default_nettype wire

/* rtl/md5_hash_engine.sv */
// Top level of the streaming MD5 engine: byte gathering, padding and compression.
//
// Usage:
//   Input channel (s_valid/s_ready, s_cmd, s_data_byte): one transaction per
//   message byte with s_cmd = absorb, then one transaction with s_cmd = finish.
//   Result channel (m_valid/m_ready): after a finish the engine returns four
//   digest words, word_index 0..3, last_word set on word 3. The low byte of
//   each word comes first in the digest.
//   Blocks: an absorb is taken while the engine is idle. The 64th byte of a block
//   starts a compression (a read-prime step, one round per cycle for 64 rounds on
//   the 16 x 32 message RAM, then a chaining add step); s_ready is low throughout.
//   Finish: the finish transaction writes the pad word, then zero to fifteen
//   zero/length writes precede one compression; a marker at byte 56 or later adds
//   sixteen writes and a second compression. Four result transactions follow, at
//   most one per cycle, with input held off; a stalled receiver holds the word.
//   Reset (aresetn low, synchronous): idle, chaining words at the MD5 initial
//   values, byte count zero. The message RAM needs no clearing, since every
//   word is written before a block is compressed.
//   After the last word the engine re-initializes for the next message.
`timescale 1ns / 1ps
`default_nettype none

module md5_hash_engine (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire logic           s_cmd,
    input  wire logic [7:0]     s_data_byte,
    output logic                m_valid,
    input  wire logic           m_ready,
    output md5_pkg::word_t      m_digest_word,
    output logic [1:0]          m_word_index,
    output logic                m_last_word
);

    import md5_pkg::*;

    localparam int AW = $clog2(WORDS_PER_BLOCK);

    localparam logic [2:0] ST_IDLE  = 3'd0;  // take bytes
    localparam logic [2:0] ST_ZERO  = 3'd1;  // write zero / length words
    localparam logic [2:0] ST_PRIME = 3'd2;  // issue first message read
    localparam logic [2:0] ST_COMP  = 3'd3;  // one round per cycle
    localparam logic [2:0] ST_FINAL = 3'd4;  // add into chaining words
    localparam logic [2:0] ST_OUT   = 3'd5;  // deliver digest

    logic [2:0]  state_reg, state_next;
    logic [60:0] count_reg, count_next;
    word_t       ch_reg [4];
    word_t       ch_next [4];
    word_t       a_reg, b_reg, c_reg, d_reg;
    word_t       a_next, b_next, c_next, d_next;
    word_t       wbuf_reg, wbuf_next;
    logic [5:0]  rnd_reg, rnd_next;
    logic [AW-1:0] wp_reg, wp_next;
    logic        fin_reg, fin_next;
    logic        spill_reg, spill_next;
    logic [1:0]  oidx_reg, oidx_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    word_t         ram_wdata;
    logic [AW-1:0] ram_raddr;
    word_t         ram_rdata;
    word_t         round_b;

    logic [5:0]  pos;
    logic [1:0]  lane;
    logic [63:0] bit_len;
    word_t       byte_word;
    word_t       pad_word;
    logic [5:0]  rnd_issue;
    logic        s_fire;
    logic        m_fire;

    assign pos     = count_reg[5:0];
    assign lane    = pos[1:0];
    assign bit_len = {count_reg, 3'b000};
    assign s_fire  = s_valid && s_ready;
    assign m_fire  = m_valid && m_ready;

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = (state_reg == ST_OUT);
    assign m_digest_word = ch_reg[oidx_reg];
    assign m_word_index  = oidx_reg;
    assign m_last_word   = (oidx_reg == 2'd3);

    // Merge the incoming byte, or the pad marker, into the word being gathered.
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            if (2'(i) == lane) begin
                byte_word[8*i +: 8] = s_data_byte;
                pad_word[8*i +: 8]  = PAD_BYTE;
            end else if (2'(i) < lane) begin
                byte_word[8*i +: 8] = wbuf_reg[8*i +: 8];
                pad_word[8*i +: 8]  = wbuf_reg[8*i +: 8];
            end else begin
                byte_word[8*i +: 8] = wbuf_reg[8*i +: 8];
                pad_word[8*i +: 8]  = 8'h00;
            end
        end
    end

    // Read one round ahead, since the RAM read data is registered.
    assign rnd_issue = (state_reg == ST_PRIME) ? 6'd0 : 6'(rnd_reg + 6'd1);
    assign ram_raddr = msg_index(rnd_issue);

    md5_ram #(
        .WIDTH (32),
        .DEPTH (WORDS_PER_BLOCK)
    ) u_msg_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    md5_round u_round (
        .rnd   (rnd_reg),
        .a     (a_reg),
        .b     (b_reg),
        .c     (c_reg),
        .d     (d_reg),
        .w     (ram_rdata),
        .b_new (round_b)
    );

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        ch_next    = ch_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        c_next     = c_reg;
        d_next     = d_reg;
        wbuf_next  = wbuf_reg;
        rnd_next   = rnd_reg;
        wp_next    = wp_reg;
        fin_next   = fin_reg;
        spill_next = spill_reg;
        oidx_next  = oidx_reg;
        ram_we     = 1'b0;
        ram_waddr  = pos[5:2];
        ram_wdata  = byte_word;

        case (state_reg)
            ST_IDLE: begin
                if (s_fire && s_cmd == CMD_ABSORB) begin
                    wbuf_next  = byte_word;
                    count_next = count_reg + 61'd1;
                    ram_we     = (lane == 2'd3);
                    if (pos == 6'd63) begin
                        state_next = ST_PRIME;
                    end
                end else if (s_fire) begin
                    // Write the word holding the pad marker, then fill the rest.
                    ram_we     = 1'b1;
                    ram_wdata  = pad_word;
                    fin_next   = 1'b1;
                    spill_next = (pos[5:3] == 3'b111);
                    wp_next    = AW'(pos[5:2] + 4'd1);
                    if (pos[5:2] == 4'(WORDS_PER_BLOCK - 1)) begin
                        state_next = ST_PRIME;
                    end else begin
                        state_next = ST_ZERO;
                    end
                end
            end
            ST_ZERO: begin
                ram_we    = 1'b1;
                ram_waddr = wp_reg;
                if (!spill_reg && wp_reg == AW'(WORDS_PER_BLOCK - 2)) begin
                    ram_wdata = bit_len[31:0];
                end else if (!spill_reg && wp_reg == AW'(WORDS_PER_BLOCK - 1)) begin
                    ram_wdata = bit_len[63:32];
                end else begin
                    ram_wdata = '0;
                end
                wp_next = AW'(wp_reg + 4'd1);
                if (wp_reg == AW'(WORDS_PER_BLOCK - 1)) begin
                    state_next = ST_PRIME;
                end
            end
            ST_PRIME: begin
                a_next     = ch_reg[0];
                b_next     = ch_reg[1];
                c_next     = ch_reg[2];
                d_next     = ch_reg[3];
                rnd_next   = 6'd0;
                state_next = ST_COMP;
            end
            ST_COMP: begin
                a_next   = d_reg;
                d_next   = c_reg;
                c_next   = b_reg;
                b_next   = round_b;
                rnd_next = 6'(rnd_reg + 6'd1);
                if (rnd_reg == 6'd63) begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL: begin
                ch_next[0] = ch_reg[0] + a_reg;
                ch_next[1] = ch_reg[1] + b_reg;
                ch_next[2] = ch_reg[2] + c_reg;
                ch_next[3] = ch_reg[3] + d_reg;
                if (fin_reg && spill_reg) begin
                    // Length block follows the spilled pad.
                    spill_next = 1'b0;
                    wp_next    = '0;
                    state_next = ST_ZERO;
                end else if (fin_reg) begin
                    oidx_next  = 2'd0;
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_OUT: begin
                if (m_fire) begin
                    oidx_next = 2'(oidx_reg + 2'd1);
                    if (oidx_reg == 2'd3) begin
                        ch_next[0] = IV_A;
                        ch_next[1] = IV_B;
                        ch_next[2] = IV_C;
                        ch_next[3] = IV_D;
                        count_next = '0;
                        fin_next   = 1'b0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            ch_reg[0] <= IV_A;
            ch_reg[1] <= IV_B;
            ch_reg[2] <= IV_C;
            ch_reg[3] <= IV_D;
            rnd_reg   <= '0;
            wp_reg    <= '0;
            fin_reg   <= 1'b0;
            spill_reg <= 1'b0;
            oidx_reg  <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            ch_reg    <= ch_next;
            rnd_reg   <= rnd_next;
            wp_reg    <= wp_next;
            fin_reg   <= fin_next;
            spill_reg <= spill_next;
            oidx_reg  <= oidx_next;
        end
    end

    // Working variables and gathered word carry no reset.
    always_ff @(posedge aclk) begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        c_reg    <= c_next;
        d_reg    <= d_next;
        wbuf_reg <= wbuf_next;
    end

endmodule

`default_nettype wire

/* rtl/md5_chk.sv */
// Port-level checker for the MD5 engine, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module md5_chk (
    input wire logic           aclk,
    input wire logic           aresetn,
    input wire logic           s_valid,
    input wire logic           s_ready,
    input wire logic           s_cmd,
    input wire logic [7:0]     s_data_byte,
    input wire logic           m_valid,
    input wire logic           m_ready,
    input wire md5_pkg::word_t m_digest_word,
    input wire logic [1:0]     m_word_index,
    input wire logic           m_last_word
);

    import md5_pkg::*;

    // Input is never taken while the digest is being delivered.
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready while digest pending");

    // A finish transaction blocks input on the next cycle.
    a_finish_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_cmd == CMD_FINISH |=> !s_ready)
        else $error("ready right after finish");

    // Digest words follow in order without gaps.
    a_word_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_word |=>
            m_valid && m_word_index == 2'($past(m_word_index) + 2'd1))
        else $error("digest word out of order");

    // Last flag marks exactly the fourth word.
    a_last_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_last_word == (m_word_index == 2'd3)))
        else $error("last_word mismatch");

    // Stalled result holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=>
            m_valid && $stable(m_digest_word) && $stable(m_word_index))
        else $error("stalled result changed");

endmodule

bind md5_hash_engine md5_chk u_md5_chk (.*);

`default_nettype wire
